[rtl/assert_macros.svh]
// Assertion macros shared by the divider RTL.
// Depends on nothing; included by modules that check their own control logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define BSID_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define BSID_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/bsid_pkg.sv]
// Shared types and constants for the binary search integer divider.
// Used by the controller, the datapath and the top level; depends on nothing.
package bsid_pkg;

	localparam int WIDTH = 32;
	localparam int CNT_W = $clog2(WIDTH);
	localparam int S_DATA_W = 2 * WIDTH;
	localparam int M_DATA_W = ((WIDTH + 7) / 8) * 8;
	localparam int M_USER_W = 2;

	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WIDTH - 1);
	localparam logic [WIDTH-1:0] ALL_ONES = '1;
	localparam logic [WIDTH-1:0] MAX_POS = {1'b0, {(WIDTH-1){1'b1}}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} cmd_t;

	function automatic logic [WIDTH-1:0] magnitude(input logic [WIDTH-1:0] v);
		return v[WIDTH-1] ? (~v + WIDTH'(1)) : v;
	endfunction

endpackage

[rtl/bsid_ctrl.sv]
// Sequencer for the divider: accepts a request, runs one search step per bit,
// then hands the result to the output register. Depends on bsid_pkg.
`include "assert_macros.svh"

module bsid_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	output bsid_pkg::cmd_t  cmd
);

	bsid_pkg::state_t state_q, state_d;
	logic [bsid_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bsid_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		cmd         = '0;
		s_tready    = 1'b0;
		out_valid_d = out_valid_q && !m_tready;
		unique case (state_q)
			bsid_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = bsid_pkg::ST_RUN;
				end
			end
			bsid_pkg::ST_RUN: begin
				cmd.step = 1'b1;
				cnt_d    = cnt_q + bsid_pkg::CNT_W'(1);
				if (cnt_q == bsid_pkg::LAST_STEP) begin
					state_d = bsid_pkg::ST_DONE;
				end
			end
			bsid_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.finish  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = bsid_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bsid_pkg::ST_IDLE;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;

	`BSID_ASSERT(a_load_then_step, clk, arst_n, cmd.load |=> cmd.step, "load not followed by step")
	`BSID_ASSERT(a_finish_shows, clk, arst_n, cmd.finish |=> m_tvalid, "finished result not valid")
	`BSID_NEVER(a_no_overwrite, clk, arst_n, cmd.finish && m_tvalid && !m_tready,
		"finish overwrote a pending result")
	`BSID_NEVER(a_busy_no_accept, clk, arst_n, s_tready && (cmd.step || cmd.finish),
		"request accepted while busy")

endmodule

[rtl/bsid_dp.sv]
// Datapath for the divider: operand magnitudes, restoring shift-subtract search
// for the quotient bits, sign fix-up and result register. Depends on bsid_pkg.
module bsid_dp (
	input  logic                       clk,
	input  bsid_pkg::cmd_t             cmd,
	input  logic [bsid_pkg::WIDTH-1:0] dividend,
	input  logic [bsid_pkg::WIDTH-1:0] divisor,
	output logic [bsid_pkg::WIDTH-1:0] quotient,
	output logic                       divide_by_zero,
	output logic                       saturated
);

	logic [bsid_pkg::WIDTH-1:0] dvd_q;
	logic [bsid_pkg::WIDTH-1:0] dsr_q;
	logic [bsid_pkg::WIDTH-1:0] rem_q;
	logic                       neg_q;
	logic                       zero_q;
	logic [bsid_pkg::WIDTH-1:0] quotient_q;
	logic                       dbz_q;
	logic                       sat_q;

	logic [bsid_pkg::WIDTH:0]   rem_shift;
	logic [bsid_pkg::WIDTH:0]   rem_diff;
	logic                       fits;

	assign rem_shift = {rem_q, dvd_q[bsid_pkg::WIDTH-1]};
	assign rem_diff  = rem_shift - {1'b0, dsr_q};
	assign fits      = !rem_diff[bsid_pkg::WIDTH];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dvd_q  <= bsid_pkg::magnitude(dividend);
			dsr_q  <= bsid_pkg::magnitude(divisor);
			rem_q  <= '0;
			neg_q  <= dividend[bsid_pkg::WIDTH-1] ^ divisor[bsid_pkg::WIDTH-1];
			zero_q <= (divisor == '0);
		end else if (cmd.step) begin
			rem_q <= fits ? rem_diff[bsid_pkg::WIDTH-1:0] : rem_shift[bsid_pkg::WIDTH-1:0];
			dvd_q <= {dvd_q[bsid_pkg::WIDTH-2:0], fits};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (zero_q) begin
				quotient_q <= bsid_pkg::ALL_ONES;
				dbz_q      <= 1'b1;
				sat_q      <= 1'b0;
			end else if (!neg_q && dvd_q[bsid_pkg::WIDTH-1]) begin
				quotient_q <= bsid_pkg::MAX_POS;
				dbz_q      <= 1'b0;
				sat_q      <= 1'b1;
			end else begin
				quotient_q <= neg_q ? (~dvd_q + bsid_pkg::WIDTH'(1)) : dvd_q;
				dbz_q      <= 1'b0;
				sat_q      <= 1'b0;
			end
		end
	end

	assign quotient       = quotient_q;
	assign divide_by_zero = dbz_q;
	assign saturated      = sat_q;

endmodule

[rtl/binary_search_integer_divide_unit.sv]
// Signed integer divider, quotient truncated toward zero, with stream ports.
// Instantiates bsid_ctrl and bsid_dp; depends on bsid_pkg and assert_macros.svh.
// Each request occupies the unit until its result is loaded: the accepting
// cycle loads the operand magnitudes, ST_RUN runs the shift-subtract search
// (one quotient bit per cycle in the single compare-subtract unit), and ST_DONE
// applies the sign and loads the output register once no earlier result is
// pending or m_tready is high. A new request is taken in the cycle after the
// result is loaded, even while it still waits for m_tready. A zero divisor
// returns minus one with divide_by_zero set; the most negative value divided by
// minus one returns the largest positive value with saturated set.
`include "assert_macros.svh"

module binary_search_integer_divide_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [31:0] dividend, [63:32] divisor
	input  logic [bsid_pkg::S_DATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [31:0] quotient
	output logic [bsid_pkg::M_DATA_W-1:0] m_tdata,
	// [0] divide_by_zero, [1] saturated
	output logic [bsid_pkg::M_USER_W-1:0] m_tuser
);

	bsid_pkg::cmd_t             cmd;
	logic [bsid_pkg::WIDTH-1:0] quotient;
	logic                       divide_by_zero;
	logic                       saturated;

	bsid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	bsid_dp u_dp (
		.clk            (clk),
		.cmd            (cmd),
		.dividend       (s_tdata[bsid_pkg::WIDTH-1:0]),
		.divisor        (s_tdata[2*bsid_pkg::WIDTH-1:bsid_pkg::WIDTH]),
		.quotient       (quotient),
		.divide_by_zero (divide_by_zero),
		.saturated      (saturated)
	);

	assign m_tdata = bsid_pkg::M_DATA_W'(quotient);
	assign m_tuser = {saturated, divide_by_zero};

	`BSID_NEVER(a_flags_exclusive, clk, arst_n, m_tvalid && m_tuser[0] && m_tuser[1],
		"both error flags set")

endmodule
